@@ hw/rtl/b2c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2c_pkg
// Shared types and constants for the bitplane to chunky expander: opcodes,
// status codes, register indexes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package b2c_pkg;

   // counters that track a whole shape: up to 16383 x 16383 bytes
   localparam int LEN_W   = 28;
   localparam int DEST_W  = LEN_W + 1;
   localparam int SIDE_W  = 14;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_START = 2'd0;
   localparam opcode_type OP_LOAD  = 2'd1;
   localparam opcode_type OP_DRAIN = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_BAD_SHAPE = 2'd1;
   localparam status_type ST_NO_DATA   = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PLANE_COLOURS     = 3'd0;
   localparam csr_index_type CSR_BACKGROUND        = 3'd1;
   localparam csr_index_type CSR_TRANSPOSE_MASK    = 3'd2;
   localparam csr_index_type CSR_TRANSPOSE_INHIBIT = 3'd3;
   localparam csr_index_type CSR_WIDTH_BYTES       = 3'd4;
   localparam csr_index_type CSR_HEIGHT_ROWS       = 3'd5;
   localparam csr_index_type CSR_PALETTE_MAP       = 3'd6;

   localparam logic [63:0] PALETTE_IDENTITY = 64'hFEDC_BA98_7654_3210;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic calc;      // register shape length, plane count, row product
      logic start;     // open a new shape and post its status
      logic load;      // store one planar byte, advance the load counters
      logic read;      // read one store word, advance the drain counter
      logic nodata;    // post a no-data result
      logic emit;      // post the expanded pixel group
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       load_ok;
      logic       drain_ok;
      logic       out_free;
   } stat_type;

endpackage

@@ hw/rtl/b2c_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2c_ctrl
// Sequencer: takes one item at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module b2c_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b2c_pkg::stat_type  stat,
   output b2c_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CALC = 4'b0010,
      S_EXEC = 4'b0100,
      S_READ = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (stat.op)
               b2c_pkg::OP_START: begin
                  if (stat.out_free) begin
                     cmd.start = 1'b1;
                     state_in  = S_IDLE;
                  end
               end
               b2c_pkg::OP_LOAD: begin
                  cmd.load = stat.load_ok;
                  state_in = S_IDLE;
               end
               b2c_pkg::OP_DRAIN: begin
                  if (stat.drain_ok) begin
                     cmd.read = 1'b1;
                     state_in = S_READ;
                  end else if (stat.out_free) begin
                     cmd.nodata = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/b2c_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2c_datapath
// Settings registers, shape counters, plane store and pixel expansion.
// ----------------------------------------------------------------------------
module b2c_datapath #(
   parameter int MAX_BYTES = 8192,
   parameter int PLANES    = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [b2c_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [b2c_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [1:0]                         req_opcode,
   input  logic [7:0]                         req_plane_byte,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [31:0]                        rsp_pixel_group,
   output logic                               rsp_last_group,
   output logic [1:0]                         rsp_status,
   input  b2c_pkg::cmd_type                   cmd,
   output b2c_pkg::stat_type                  stat
);

   localparam int NP = (PLANES < 4) ? PLANES : 4;
   localparam int SW = 8 * NP;
   localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int PW = $clog2(NP + 1);
   localparam int LW = b2c_pkg::LEN_W;
   localparam int DW = b2c_pkg::DEST_W;
   localparam int HW = b2c_pkg::SIDE_W;
   localparam logic [LW-1:0] STORE_LEN  = LW'(MAX_BYTES);
   localparam logic [DW-1:0] STORE_DEST = DW'(MAX_BYTES);

   // settings
   logic [15:0]   plane_colours_ff;
   logic [3:0]    background_ff;
   logic [3:0]    tmask_ff;
   logic          tinhibit_ff;
   logic [HW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [63:0]   palette_ff;

   // current item and per-item values
   b2c_pkg::opcode_type opcode_ff;
   logic [7:0]          byte_ff;
   logic [LW-1:0]       len_ff;
   logic [LW-1:0]       prod_ff;
   logic [PW-1:0]       np_ff;

   // shape state
   logic [LW-1:0] load_count_ff, load_count_in;
   logic [LW-1:0] column_ff, column_in;
   logic [HW-1:0] row_ff, row_in;
   logic [PW-1:0] plane_ff, plane_in;
   logic [LW-1:0] drain_ff, drain_in;
   logic          open_ff, open_in;

   // store and read side
   logic [SW-1:0] store_mem [MAX_BYTES];
   logic [SW-1:0] rd_data_ff;
   logic          rd_zero_ff;
   logic          last_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            group_ff;
   logic                   last_out_ff;
   b2c_pkg::status_type    status_ff;

   logic [PW-1:0] np_c;
   logic          np_stop;
   logic          transpose_c;
   logic [DW-1:0] dest_c;
   logic          dest_ok;
   logic          bad_c;
   logic [HW:0]   row_next;
   logic [LW-1:0] load_next;
   logic [SW-1:0] word_c;
   logic [31:0]   pix_c;
   logic [3:0]    raw_c;
   logic          post_c;

   // settings port
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_colours_ff <= '0;
         background_ff    <= '0;
         tmask_ff         <= '0;
         tinhibit_ff      <= 1'b0;
         width_ff         <= HW'(1);
         height_ff        <= HW'(1);
         palette_ff       <= b2c_pkg::PALETTE_IDENTITY;
      end else if (csr_write_en) begin
         case (csr_index)
            b2c_pkg::CSR_PLANE_COLOURS:     plane_colours_ff <= csr_wdata[15:0];
            b2c_pkg::CSR_BACKGROUND:        background_ff    <= csr_wdata[3:0];
            b2c_pkg::CSR_TRANSPOSE_MASK:    tmask_ff         <= csr_wdata[3:0];
            b2c_pkg::CSR_TRANSPOSE_INHIBIT: tinhibit_ff      <= csr_wdata[0];
            b2c_pkg::CSR_WIDTH_BYTES:       width_ff         <= csr_wdata[HW-1:0];
            b2c_pkg::CSR_HEIGHT_ROWS:       height_ff        <= csr_wdata[HW-1:0];
            b2c_pkg::CSR_PALETTE_MAP:       palette_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // leading run of nonzero plane colours
   always_comb begin
      np_c    = '0;
      np_stop = 1'b0;
      for (int j = 0; j < NP; j++) begin
         if (plane_colours_ff[4*j +: 4] == 4'd0) np_stop = 1'b1;
         if (!np_stop) np_c = np_c + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req_opcode;
         byte_ff   <= req_plane_byte;
      end
      if (cmd.calc) begin
         len_ff  <= LW'(width_ff) * LW'(height_ff);
         prod_ff <= LW'(row_ff) * LW'(width_ff);
         np_ff   <= np_c;
      end
   end

   // load addressing
   always_comb begin
      transpose_c = 1'b0;
      for (int j = 0; j < NP; j++) begin
         if (plane_ff == PW'(j)) transpose_c = tmask_ff[j];
      end
      transpose_c = transpose_c && !tinhibit_ff;
      dest_c  = transpose_c ? ({1'b0, prod_ff} + {1'b0, column_ff}) : {1'b0, load_count_ff};
      dest_ok = dest_c < STORE_DEST;
   end

   assign bad_c = (np_ff == '0) || (width_ff == '0) || (height_ff == '0) ||
                  (len_ff > STORE_LEN);

   assign stat.op       = opcode_ff;
   assign stat.load_ok  = open_ff && (plane_ff < np_ff);
   assign stat.drain_ok = open_ff && (plane_ff >= np_ff) && (drain_ff < len_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // counter updates
   always_comb begin
      load_count_in = load_count_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      plane_in      = plane_ff;
      drain_in      = drain_ff;
      open_in       = open_ff;
      row_next      = {1'b0, row_ff} + (HW+1)'(1);
      load_next     = load_count_ff + LW'(1);
      if (cmd.start) begin
         load_count_in = '0;
         column_in     = '0;
         row_in        = '0;
         plane_in      = '0;
         drain_in      = '0;
         open_in       = !bad_c;
      end else if (cmd.load) begin
         if (row_next >= {1'b0, height_ff}) begin
            row_in    = '0;
            column_in = column_ff + LW'(1);
         end else begin
            row_in = row_next[HW-1:0];
         end
         load_count_in = load_next;
         if (load_next >= len_ff) begin
            load_count_in = '0;
            row_in        = '0;
            column_in     = '0;
            plane_in      = plane_ff + PW'(1);
         end
      end else if (cmd.read) begin
         drain_in = drain_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         plane_ff      <= '0;
         drain_ff      <= '0;
         open_ff       <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         plane_ff      <= plane_in;
         drain_ff      <= drain_in;
         open_ff       <= open_in;
      end
   end

   // plane store: one byte lane per plane
   always_ff @(posedge clock) begin
      if (cmd.load && dest_ok) begin
         for (int j = 0; j < NP; j++) begin
            if (plane_ff == PW'(j)) store_mem[dest_c[AW-1:0]][8*j +: 8] <= byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= store_mem[drain_ff[AW-1:0]];
         rd_zero_ff <= drain_ff >= STORE_LEN;
         last_ff    <= (drain_ff + LW'(1)) == len_ff;
      end
   end

   // expand eight pixels, leftmost from each byte's msb
   always_comb begin
      word_c = rd_zero_ff ? '0 : rd_data_ff;
      pix_c  = '0;
      raw_c  = '0;
      for (int l = 0; l < 8; l++) begin
         raw_c = background_ff;
         for (int j = 0; j < NP; j++) begin
            if ((PW'(j) < np_ff) && word_c[8*j + 7 - l]) begin
               raw_c = raw_c | plane_colours_ff[4*j +: 4];
            end
         end
         pix_c[4*(7-l) +: 4] = palette_ff[{raw_c, 2'b00} +: 4];
      end
   end

   // result register
   assign post_c       = cmd.start || cmd.nodata || cmd.emit;
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || post_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         group_ff    <= pix_c;
         last_out_ff <= last_ff;
         status_ff   <= b2c_pkg::ST_OK;
      end else if (cmd.start) begin
         group_ff    <= '0;
         last_out_ff <= 1'b0;
         status_ff   <= bad_c ? b2c_pkg::ST_BAD_SHAPE : b2c_pkg::ST_OK;
      end else if (cmd.nodata) begin
         group_ff    <= '0;
         last_out_ff <= 1'b0;
         status_ff   <= b2c_pkg::ST_NO_DATA;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_group = group_ff;
   assign rsp_last_group  = last_out_ff;
   assign rsp_status      = status_ff;

endmodule

@@ hw/rtl/bitplane_to_chunky_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_to_chunky_expander
// Planar to chunky conversion: planar bytes are gathered plane by plane into
// a word-per-byte store, then drained as groups of eight 4-bit pixels.
// ----------------------------------------------------------------------------
//
//   channel   direction  transfer when            payload
//   req_*     in         req_valid & req_ready    opcode, plane_byte
//   rsp_*     out        rsp_valid & rsp_ready    pixel_group, last_group, status
//   csr_*     in         csr_write_en             index, wdata (no read-back)
//
// one item at a time: every item steps through idle, the settle of length
// and row product through the 14x14 multipliers, and execute; a drain with
// data adds the registered store read, while start, load and a no-data
// drain return to idle from execute
// start, no-data drain and pixel drain wait in place while the result
// register is still full and rsp_ready is low; a new item can enter while
// a finished result waits
// reset clears settings to their defaults and all shape counters; the store
// is not cleared and needs no clearing pass
//
module bitplane_to_chunky_expander #(
   parameter int MAX_BYTES = 8192,
   parameter int PLANES    = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_opcode,
   input  logic [7:0]                     req_plane_byte,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_pixel_group,
   output logic                           rsp_last_group,
   output logic [1:0]                     rsp_status,
   // settings write port
   input  logic                           csr_write_en,
   input  logic [b2c_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [b2c_pkg::CSR_W-1:0]      csr_wdata
);

   // sequencer commands and datapath conditions
   b2c_pkg::cmd_type  cmd;
   b2c_pkg::stat_type stat;

   b2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // settings, counters, plane store and pixel expansion
   b2c_datapath #(
      .MAX_BYTES (MAX_BYTES),
      .PLANES    (PLANES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_opcode),
      .req_plane_byte  (req_plane_byte),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_group (rsp_pixel_group),
      .rsp_last_group  (rsp_last_group),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitplane to chunky expander. Shapes are opened,
// loaded plane by plane and drained under many settings, including bad
// shapes, transposed planes and broken load sequences. Every result transfer
// is checked field by field against an in-bench model of the expander.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          CLK_PERIOD  = 10;
   localparam int          STORE_WORDS = 8192;
   localparam int          PLANE_SLOTS = 4;
   localparam int          TAIL_CYCLES = 16;
   localparam int          CYCLE_LIMIT = 2_500_000;
   localparam int          RANDOM_ITEMS = 550;
   localparam b2c_pkg::opcode_type OP_UNUSED = 2'd3;

   typedef struct packed {
      b2c_pkg::opcode_type op;
      logic [7:0]          pbyte;
   } pending_item_type;

   typedef struct packed {
      logic [31:0]         pixel_group;
      logic                last_group;
      b2c_pkg::status_type status;
   } pixel_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // dut ports
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode     = b2c_pkg::OP_START;
   logic [7:0]                    req_plane_byte = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic [31:0]                   rsp_pixel_group;
   logic                          rsp_last_group;
   logic [1:0]                    rsp_status;
   logic                          csr_write_en   = 1'b0;
   logic [b2c_pkg::CSR_IDX_W-1:0] csr_index      = b2c_pkg::CSR_PLANE_COLOURS;
   logic [b2c_pkg::CSR_W-1:0]     csr_wdata      = '0;

   bitplane_to_chunky_expander u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_plane_byte  (req_plane_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_group (rsp_pixel_group),
      .rsp_last_group  (rsp_last_group),
      .rsp_status      (rsp_status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // --------------------------------------------------------------------------
   // expander model: settings copy, plane store and shape counters
   // --------------------------------------------------------------------------
   logic [15:0] cfg_colours    = 16'h0000;
   logic [3:0]  cfg_background = 4'h0;
   logic [3:0]  cfg_tmask      = 4'h0;
   logic        cfg_tinhibit   = 1'b0;
   logic [13:0] cfg_width      = 14'd1;
   logic [13:0] cfg_height     = 14'd1;
   logic [63:0] cfg_palette    = b2c_pkg::PALETTE_IDENTITY;

   bit [31:0]   plane_words [STORE_WORDS];
   int unsigned bytes_in_plane, planes_done, linear_addr, col_pos, row_pos;
   int unsigned groups_out;
   bit          shape_bad, shape_live;

   pixel_result_type expected_groups [$];
   pending_item_type pending_items [$];

   int          fail_count  = 0;
   int          items_pushed = 0;
   bit          item_on_bus = 1'b0;

   // planes in use: stop at the first zero colour nibble
   function automatic int unsigned active_planes();
      int unsigned n;
      n = 0;
      while (n < PLANE_SLOTS && cfg_colours[4*n +: 4] != 4'd0) n++;
      return n;
   endfunction

   // advance the model by one accepted item, return the result it causes
   task automatic expand_item(input b2c_pkg::opcode_type op, input logic [7:0] pbyte,
                              output bit produces, output pixel_result_type res);
      int unsigned np, len, dest, l, j;
      bit          flip;
      logic [31:0] word;
      logic [3:0]  colour;
      np       = active_planes();
      len      = 32'(cfg_width) * 32'(cfg_height);
      produces = 1'b0;
      res      = '0;
      case (op)
         b2c_pkg::OP_START: begin
            shape_bad      = np == 0 || cfg_width == 0 || cfg_height == 0 ||
                             len > STORE_WORDS;
            shape_live     = !shape_bad;
            bytes_in_plane = 0;
            planes_done    = 0;
            linear_addr    = 0;
            col_pos        = 0;
            row_pos        = 0;
            groups_out     = 0;
            res.status     = shape_bad ? b2c_pkg::ST_BAD_SHAPE : b2c_pkg::ST_OK;
            produces       = 1'b1;
         end
         b2c_pkg::OP_LOAD: begin
            if (shape_live && !shape_bad && planes_done < np) begin
               // transposed planes arrive column-major, land row-major
               flip = !cfg_tinhibit && cfg_tmask[planes_done];
               dest = flip ? row_pos * 32'(cfg_width) + col_pos : linear_addr;
               if (dest < STORE_WORDS) plane_words[dest][8*planes_done +: 8] = pbyte;
               linear_addr++;
               row_pos++;
               if (row_pos >= cfg_height) begin
                  row_pos = 0;
                  col_pos++;
               end
               bytes_in_plane++;
               if (bytes_in_plane >= len) begin
                  bytes_in_plane = 0;
                  linear_addr    = 0;
                  row_pos        = 0;
                  col_pos        = 0;
                  planes_done++;
               end
            end
         end
         b2c_pkg::OP_DRAIN: begin
            produces   = 1'b1;
            res.status = b2c_pkg::ST_NO_DATA;
            if (shape_live && !shape_bad && planes_done >= np && groups_out < len) begin
               word = groups_out < STORE_WORDS ? plane_words[groups_out] : 32'd0;
               for (l = 0; l < 8; l++) begin
                  colour = cfg_background;
                  for (j = 0; j < np; j++)
                     if (word[8*j + 7 - l]) colour |= cfg_colours[4*j +: 4];
                  res.pixel_group[28 - 4*l +: 4] = cfg_palette[4*colour +: 4];
               end
               res.last_group = groups_out + 1 == len;
               res.status     = b2c_pkg::ST_OK;
               groups_out++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // idle length per item, with occasional stretches of back-to-back traffic
   task automatic pick_gap(inout int burst, output int gap);
      if (burst > 0) begin
         burst--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 31) == 0) burst = $urandom_range(8, 40);
      end
   endtask

   // --------------------------------------------------------------------------
   // driver: feeds pending items onto req_*, runs the model on each transfer
   // --------------------------------------------------------------------------
   int               tx_wait  = 0;
   int               tx_burst = 0;
   bit               tx_has_rsp;
   pixel_result_type tx_res;
   pending_item_type tx_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expand_item(req_opcode, req_plane_byte, tx_has_rsp, tx_res);
            if (tx_has_rsp) expected_groups.push_back(tx_res);
            item_on_bus = 1'b0;
            pick_gap(tx_burst, tx_wait);
         end
         if (!item_on_bus) begin
            if (tx_wait > 0) begin
               tx_wait--;
            end else if (pending_items.size() > 0) begin
               tx_next = pending_items.pop_front();
               req_opcode     <= tx_next.op;
               req_plane_byte <= tx_next.pbyte;
               item_on_bus = 1'b1;
            end
         end
         // one assignment per edge keeps valid solid across back-to-back items
         req_valid <= item_on_bus;
      end
   end

   // --------------------------------------------------------------------------
   // monitor: random rsp_ready, long hold-offs, field checks per transfer
   // --------------------------------------------------------------------------
   int               rx_wait      = 0;
   int               rx_burst     = 0;
   int               rx_hold      = 0;
   int               results_seen = 0;
   bit               rx_ready_next;
   pixel_result_type rx_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_groups.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d group %h",
                                         rsp_status, rsp_pixel_group));
            end else begin
               rx_want = expected_groups.pop_front();
               if (rsp_pixel_group !== rx_want.pixel_group)
                  report_mismatch($sformatf("result %0d pixel_group %h, want %h",
                                            results_seen, rsp_pixel_group,
                                            rx_want.pixel_group));
               if (rsp_last_group !== rx_want.last_group)
                  report_mismatch($sformatf("result %0d last_group %b, want %b",
                                            results_seen, rsp_last_group,
                                            rx_want.last_group));
               if (rsp_status !== rx_want.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, rsp_status, rx_want.status));
            end
            pick_gap(rx_burst, rx_wait);
            // long back-pressure while drains keep coming: the block must fill
            // up and hold req_ready low
            if (results_seen == 30 || results_seen == 400 || results_seen == 9000)
               rx_hold = 250;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rx_ready_next = 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rx_ready_next = 1'b0;
         end else begin
            rx_ready_next = 1'b1;
         end
         rsp_ready <= rx_ready_next;
      end
   end

   // run-away guard
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   task automatic push_item(input b2c_pkg::opcode_type op, input logic [7:0] pbyte);
      pending_item_type it;
      it.op    = op;
      it.pbyte = pbyte;
      pending_items.push_back(it);
      if (op != OP_UNUSED) items_pushed++;
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // every transfer done, every result back, and loads given time to retire
   task automatic wait_idle();
      while (pending_items.size() != 0 || item_on_bus || expected_groups.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // settings only change while the block is idle
   task automatic apply_settings(input logic [15:0] colours, input logic [3:0] bg,
                                 input logic [3:0] tmask, input logic tinhibit,
                                 input logic [13:0] width, input logic [13:0] height,
                                 input logic [63:0] palette);
      b2c_pkg::csr_index_type idx;
      logic [63:0]            value;
      for (int r = 0; r <= b2c_pkg::CSR_PALETTE_MAP; r++) begin
         idx = b2c_pkg::csr_index_type'(r);
         case (idx)
            b2c_pkg::CSR_PLANE_COLOURS: begin
               value = 64'(colours);
               cfg_colours = colours;
            end
            b2c_pkg::CSR_BACKGROUND: begin
               value = 64'(bg);
               cfg_background = bg;
            end
            b2c_pkg::CSR_TRANSPOSE_MASK: begin
               value = 64'(tmask);
               cfg_tmask = tmask;
            end
            b2c_pkg::CSR_TRANSPOSE_INHIBIT: begin
               value = 64'(tinhibit);
               cfg_tinhibit = tinhibit;
            end
            b2c_pkg::CSR_WIDTH_BYTES: begin
               value = 64'(width);
               cfg_width = width;
            end
            b2c_pkg::CSR_HEIGHT_ROWS: begin
               value = 64'(height);
               cfg_height = height;
            end
            default: begin
               value = palette;
               cfg_palette = palette;
            end
         endcase
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= value;
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one shape: start, all planes, all groups; sometimes broken or noisy
   task automatic run_shape();
      int unsigned np, len, total, cut, i;
      np  = active_planes();
      len = 32'(cfg_width) * 32'(cfg_height);
      push_item(b2c_pkg::OP_START, random_byte());
      if (np == 0 || len > STORE_WORDS) begin
         // rejected shape: loads are dropped and drains find nothing
         push_item(b2c_pkg::OP_LOAD, random_byte());
         push_item(b2c_pkg::OP_DRAIN, random_byte());
         return;
      end
      total = np * len;
      cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
      for (i = 0; i < cut; i++) begin
         push_item(b2c_pkg::OP_LOAD, random_byte());
         if ($urandom_range(0, 39) == 0)
            push_item($urandom_range(0, 1) ? b2c_pkg::OP_DRAIN : OP_UNUSED,
                      random_byte());
      end
      if (cut < total) begin
         // planes incomplete: drain must report no data
         push_item(b2c_pkg::OP_DRAIN, random_byte());
         return;
      end
      if ($urandom_range(0, 3) == 0) push_item(b2c_pkg::OP_LOAD, random_byte());
      for (i = 0; i < len; i++) push_item(b2c_pkg::OP_DRAIN, random_byte());
      repeat ($urandom_range(0, 2)) push_item(b2c_pkg::OP_DRAIN, random_byte());
   endtask

   // --------------------------------------------------------------------------
   // test sequence
   // --------------------------------------------------------------------------
   initial begin
      int unsigned k, j, random_base;
      logic [15:0] colours;
      logic [13:0] width, height;
      logic [63:0] palette;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings have no plane colour: drain before any start, a load
      // with no shape open, rejected start, drain after it, opcode three
      push_item(b2c_pkg::OP_DRAIN, 8'h00);
      push_item(b2c_pkg::OP_LOAD, 8'hFF);
      push_item(b2c_pkg::OP_START, 8'h00);
      push_item(b2c_pkg::OP_DRAIN, 8'h00);
      push_item(OP_UNUSED, 8'hAA);
      wait_idle();

      // 2x2 shape, two planes (zero nibble ends the list, top nibble ignored),
      // plane 1 transposed; early drain, extra load, drain past the end
      apply_settings(16'h5091, 4'h2, 4'b0010, 1'b0, 14'd2, 14'd2,
                     64'h0123_4567_89AB_CDEF);
      push_item(b2c_pkg::OP_START, 8'h00);
      push_item(b2c_pkg::OP_DRAIN, 8'h00);
      push_item(b2c_pkg::OP_LOAD, 8'h80);
      push_item(b2c_pkg::OP_LOAD, 8'h01);
      push_item(b2c_pkg::OP_LOAD, 8'hFF);
      push_item(b2c_pkg::OP_LOAD, 8'h00);
      push_item(b2c_pkg::OP_LOAD, 8'hF0);
      push_item(b2c_pkg::OP_LOAD, 8'h0F);
      push_item(b2c_pkg::OP_LOAD, 8'hAA);
      push_item(b2c_pkg::OP_LOAD, 8'h55);
      push_item(b2c_pkg::OP_LOAD, 8'h3C);
      repeat (5) push_item(b2c_pkg::OP_DRAIN, 8'h00);
      wait_idle();

      // shape larger than the store, transposition inhibited
      apply_settings(16'hFFFF, 4'hF, 4'hF, 1'b1, 14'd8192, 14'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      push_item(b2c_pkg::OP_START, 8'h00);
      wait_idle();

      // tallest shape that fits, drained before any load
      apply_settings(16'hFFFF, 4'h0, 4'hF, 1'b0, 14'd1, 14'd8192, 64'h0);
      push_item(b2c_pkg::OP_START, 8'h00);
      push_item(b2c_pkg::OP_DRAIN, 8'h00);
      wait_idle();

      // wider shape, single transposed plane over several rows
      apply_settings(16'h0007, 4'h8, 4'h1, 1'b0, 14'd40, 14'd3,
                     {$urandom, $urandom});
      run_shape();
      wait_idle();

      // random settings, mostly small shapes
      random_base = items_pushed;
      while (items_pushed - random_base < RANDOM_ITEMS) begin
         k       = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, PLANE_SLOTS);
         colours = 16'($urandom);
         for (j = 0; j < k; j++) colours[4*j +: 4] = 4'($urandom_range(1, 15));
         if (k < PLANE_SLOTS) colours[4*k +: 4] = 4'd0;
         if ($urandom_range(0, 15) == 0) colours = 16'hFFFF;
         if ($urandom_range(0, 11) == 0) begin
            // oversize: one row more than the store can take
            width  = 14'($urandom_range(2, STORE_WORDS));
            height = 14'(STORE_WORDS / width + 1);
         end else begin
            width  = 14'($urandom_range(1, 6));
            height = 14'($urandom_range(1, 6));
         end
         case ($urandom_range(0, 7))
            0, 1:    palette = b2c_pkg::PALETTE_IDENTITY;
            2:       palette = 64'h0;
            3:       palette = 64'hFFFF_FFFF_FFFF_FFFF;
            default: palette = {$urandom, $urandom};
         endcase
         apply_settings(colours,
                        ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom),
                        4'($urandom),
                        $urandom_range(0, 3) == 0,
                        width, height, palette);
         repeat ($urandom_range(1, 3)) run_shape();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
